/* design/qau_pkg.sv */
// Shared widths, command and status codes and lane and norm result types of the quaternion unit.
package qau_pkg;

   localparam int W          = 16;
   localparam int FB         = 12;
   localparam int NORM_W     = 21;
   localparam int LANES      = 4;
   localparam int PROD_W     = 2 * W;
   localparam int DOT_W      = 2 * W + 2;
   localparam int RES_W      = DOT_W - FB;
   localparam int SQ_W       = 2 * W - 1;
   localparam int SUM_W      = 2 * W + 1;
   localparam int NUM_W      = W + 2 * FB;
   localparam int QB         = W + 1;
   localparam int CMP_W      = SUM_W + QB;
   localparam int NRM_FULL_W = SUM_W - FB + 1;
   localparam int NORM_DLY   = QB + 2;
   localparam int PIPE_DEPTH = QB + 5;

   localparam logic [3:0] CMD_ADD  = 4'd0;
   localparam logic [3:0] CMD_SUB  = 4'd1;
   localparam logic [3:0] CMD_NEG  = 4'd2;
   localparam logic [3:0] CMD_CONJ = 4'd3;
   localparam logic [3:0] CMD_PROD = 4'd4;
   localparam logic [3:0] CMD_SCL  = 4'd5;
   localparam logic [3:0] CMD_DIVS = 4'd6;
   localparam logic [3:0] CMD_DIVC = 4'd7;
   localparam logic [3:0] CMD_INV  = 4'd8;
   localparam logic [3:0] CMD_NORM = 4'd9;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIVZ = 2'd2;

   typedef struct packed {
      logic signed [RES_W-1:0] value;
      logic                    dz;
   } lane_out_type;

   typedef struct packed {
      logic [NORM_W-1:0] nrm;
      logic              sat;
   } norm_out_type;

endpackage

/* design/qau_norm.sv */
// Squared length of the first operand, rounded and delayed to line up with the lanes.
module qau_norm
   import qau_pkg::*;
(
   input  logic                        clock,
   input  logic                        en,
   input  logic [LANES-1:0][W-1:0]     a,
   output logic [SUM_W-1:0]            norm_sum,
   output norm_out_type                norm_out
);

   logic [SQ_W-1:0]       sq_ff [LANES];
   logic [SQ_W-1:0]       sq_in [LANES];
   logic [SUM_W-1:0]      sum_ff, sum_in;
   norm_out_type          dly_ff [NORM_DLY];
   norm_out_type          dly_in [NORM_DLY];
   logic [W-1:0]          amag [LANES];
   logic [2*W-1:0]        sq_full [LANES];
   logic [NRM_FULL_W-1:0] nrm_full;
   norm_out_type          nrm_now;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         amag[k]    = a[k][W-1] ? (~a[k] + W'(1)) : a[k];
         sq_full[k] = amag[k] * amag[k];
         sq_in[k]   = sq_full[k][SQ_W-1:0];
      end
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);
   end

   always_comb begin
      nrm_full = NRM_FULL_W'(sum_ff[SUM_W-1:FB]) + NRM_FULL_W'(sum_ff[FB-1]);
      if (nrm_full > NRM_FULL_W'({NORM_W{1'b1}})) begin
         nrm_now.nrm = '1;
         nrm_now.sat = 1'b1;
      end else begin
         nrm_now.nrm = nrm_full[NORM_W-1:0];
         nrm_now.sat = 1'b0;
      end
      dly_in[0] = nrm_now;
      for (int k = 1; k < NORM_DLY; k++) begin
         dly_in[k] = dly_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= sq_in;
         sum_ff <= sum_in;
         dly_ff <= dly_in;
      end
   end

   assign norm_sum = sum_ff;
   assign norm_out = dly_ff[NORM_DLY-1];

endmodule

/* design/qau_lane.sv */
// One component lane: products, direct results and a bit-per-stage rounding divider.
module qau_lane
   import qau_pkg::*;
(
   input  logic                        clock,
   input  logic                        en,
   input  logic                        real_part,
   input  logic [3:0]                  cmd,
   input  logic [LANES-1:0][W-1:0]     hp_a,
   input  logic [LANES-1:0][W-1:0]     hp_b,
   input  logic [LANES-1:0]            hp_neg,
   input  logic [W-1:0]                own_b,
   input  logic [W-1:0]                factor,
   input  logic [SUM_W-1:0]            norm_sum,
   output lane_out_type                lane_out
);

   typedef struct packed {
      logic [NUM_W-1:0]        rem;
      logic [QB-1:0]           quo;
      logic [SUM_W-1:0]        den;
      logic                    neg;
      logic                    ovf;
      logic                    is_div;
      logic                    dz;
      logic signed [RES_W-1:0] res;
   } div_type;

   localparam logic signed [DOT_W-1:0] RND_HALF = DOT_W'(2 ** (FB - 1));

   logic [3:0]              cmd1_ff, cmd1_in;
   logic signed [W-1:0]     a1_ff, a1_in, b1_ff, b1_in, f1_ff, f1_in;
   logic signed [PROD_W-1:0] prod1_ff [LANES];
   logic signed [PROD_W-1:0] prod1_in [LANES];
   logic signed [PROD_W-1:0] pm [LANES];
   logic signed [PROD_W-1:0] scl1_ff, scl1_in;

   logic [3:0]              cmd2_ff;
   logic signed [W-1:0]     a2_ff, b2_ff, f2_ff;
   logic signed [RES_W-1:0] res2_ff, res2_in;
   logic signed [DOT_W-1:0] dot, rnd_dot, rnd_scl;

   logic [W-1:0]            amag, bmag, fmag;
   logic [NUM_W-1:0]        num;
   div_type                 st_ff [QB+1];
   div_type                 st_in [QB+1];

   logic                    up;
   logic [QB:0]             qm;
   logic signed [RES_W-1:0] qval;
   lane_out_type            out_ff, out_in;

   always_comb begin
      cmd1_in = cmd;
      a1_in   = hp_a[0];
      b1_in   = own_b;
      f1_in   = factor;
      for (int k = 0; k < LANES; k++) begin
         pm[k]       = $signed(hp_a[k]) * $signed(hp_b[k]);
         prod1_in[k] = hp_neg[k] ? -pm[k] : pm[k];
      end
      scl1_in = $signed(hp_a[0]) * $signed(factor);
   end

   always_comb begin
      dot = DOT_W'(prod1_ff[0]) + DOT_W'(prod1_ff[1]) + DOT_W'(prod1_ff[2])
          + DOT_W'(prod1_ff[3]);
      rnd_dot = (dot + RND_HALF) >>> FB;
      rnd_scl = (DOT_W'(scl1_ff) + RND_HALF) >>> FB;
      case (cmd1_ff)
         CMD_ADD:  res2_in = RES_W'(a1_ff) + RES_W'(b1_ff);
         CMD_SUB:  res2_in = RES_W'(a1_ff) - RES_W'(b1_ff);
         CMD_NEG:  res2_in = -RES_W'(a1_ff);
         CMD_CONJ: res2_in = real_part ? RES_W'(a1_ff) : -RES_W'(a1_ff);
         CMD_PROD: res2_in = rnd_dot[RES_W-1:0];
         CMD_SCL:  res2_in = rnd_scl[RES_W-1:0];
         default:  res2_in = '0;
      endcase
   end

   always_comb begin
      amag = a2_ff[W-1] ? W'(-a2_ff) : a2_ff;
      bmag = b2_ff[W-1] ? W'(-b2_ff) : b2_ff;
      fmag = f2_ff[W-1] ? W'(-f2_ff) : f2_ff;
      st_in[0].quo    = '0;
      st_in[0].res    = res2_ff;
      st_in[0].is_div = 1'b1;
      case (cmd2_ff)
         CMD_DIVS: begin
            num             = {{(NUM_W-W){1'b0}}, amag} << FB;
            st_in[0].den    = {{(SUM_W-W){1'b0}}, fmag};
            st_in[0].neg    = a2_ff[W-1] ^ f2_ff[W-1];
            st_in[0].dz     = (f2_ff == '0);
         end
         CMD_DIVC: begin
            num             = {{(NUM_W-W){1'b0}}, amag} << FB;
            st_in[0].den    = {{(SUM_W-W){1'b0}}, bmag};
            st_in[0].neg    = a2_ff[W-1] ^ b2_ff[W-1];
            st_in[0].dz     = (b2_ff == '0);
         end
         CMD_INV: begin
            num             = {{(NUM_W-W){1'b0}}, amag} << (2 * FB);
            st_in[0].den    = norm_sum;
            st_in[0].neg    = real_part ? a2_ff[W-1] : ~a2_ff[W-1];
            st_in[0].dz     = (norm_sum == '0);
         end
         default: begin
            num             = '0;
            st_in[0].den    = SUM_W'(1);
            st_in[0].neg    = 1'b0;
            st_in[0].dz     = 1'b0;
            st_in[0].is_div = 1'b0;
         end
      endcase
      st_in[0].rem = num;
      st_in[0].ovf = {{(CMP_W-NUM_W){1'b0}}, num} >= {st_in[0].den, {QB{1'b0}}};
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [CMP_W-1:0] sh_den;
      logic [CMP_W-1:0] rem_ext;
      logic [CMP_W-1:0] diff;
      always_comb begin
         sh_den   = {{QB{1'b0}}, st_ff[k].den} << (QB - 1 - k);
         rem_ext  = {{(CMP_W-NUM_W){1'b0}}, st_ff[k].rem};
         diff     = rem_ext - sh_den;
         st_in[k+1] = st_ff[k];
         if (rem_ext >= sh_den) begin
            st_in[k+1].rem           = diff[NUM_W-1:0];
            st_in[k+1].quo[QB-1-k]   = 1'b1;
         end
      end
   end

   always_comb begin
      up   = {{(CMP_W-NUM_W-1){1'b0}}, st_ff[QB].rem, 1'b0}
           >= {{QB{1'b0}}, st_ff[QB].den};
      qm   = st_ff[QB].ovf ? '1 : ({1'b0, st_ff[QB].quo} + (QB+1)'(up));
      qval = st_ff[QB].neg ? -RES_W'(qm) : RES_W'(qm);
      out_in.value = st_ff[QB].is_div ? qval : st_ff[QB].res;
      out_in.dz    = st_ff[QB].is_div & st_ff[QB].dz;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff  <= cmd1_in;
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
         f1_ff    <= f1_in;
         prod1_ff <= prod1_in;
         scl1_ff  <= scl1_in;
         cmd2_ff  <= cmd1_ff;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         f2_ff    <= f1_ff;
         res2_ff  <= res2_in;
         st_ff    <= st_in;
         out_ff   <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

/* design/qau_merge.sv */
// Merge stage: clamp lane results, zero them on division by zero, fold the status and register the result beat.
module qau_merge
   import qau_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  lane_out_type         lane_out [LANES],
   input  norm_out_type         norm_out,
   output logic [LANES-1:0][W-1:0] comp,
   output logic [NORM_W-1:0]    norm_sq,
   output logic [1:0]           status
);

   localparam logic signed [RES_W-1:0] MAXV = RES_W'(2 ** (W - 1) - 1);
   localparam logic signed [RES_W-1:0] MINV = RES_W'(-(2 ** (W - 1)));

   logic [LANES-1:0][W-1:0] comp_ff, comp_in;
   logic [NORM_W-1:0]       norm_ff;
   logic [1:0]              status_ff, status_in;
   logic                    any_dz, any_sat;

   always_comb begin
      any_dz  = 1'b0;
      any_sat = norm_out.sat;
      for (int k = 0; k < LANES; k++) begin
         any_dz = any_dz | lane_out[k].dz;
         if (lane_out[k].value > MAXV) begin
            comp_in[k] = MAXV[W-1:0];
            any_sat    = 1'b1;
         end else if (lane_out[k].value < MINV) begin
            comp_in[k] = MINV[W-1:0];
            any_sat    = 1'b1;
         end else begin
            comp_in[k] = lane_out[k].value[W-1:0];
         end
      end
      if (any_dz) begin
         comp_in   = '0;
         status_in = ST_DIVZ;
      end else if (any_sat) begin
         status_in = ST_SAT;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         comp_ff   <= comp_in;
         norm_ff   <= norm_out.nrm;
         status_ff <= status_in;
      end
   end

   assign comp    = comp_ff;
   assign norm_sq = norm_ff;
   assign status  = status_ff;

endmodule

/* design/quaternion_arithmetic_unit_top.sv */
// Throughput: one beat per cycle while no response beat is stalled; the four lanes
// each run a 17-stage one-bit-per-stage divider, so every operation walks the same
// 22-register pipeline.
// A stalled response holds the whole pipeline; request stall follows response stall then.
// Reset (synchronous, active high) clears only the pipeline valid bits.
module quaternion_arithmetic_unit_top
   import qau_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_cmd,
   input  logic signed [15:0]  req_a_x,
   input  logic signed [15:0]  req_a_y,
   input  logic signed [15:0]  req_a_z,
   input  logic signed [15:0]  req_a_w,
   input  logic signed [15:0]  req_b_x,
   input  logic signed [15:0]  req_b_y,
   input  logic signed [15:0]  req_b_z,
   input  logic signed [15:0]  req_b_w,
   input  logic signed [15:0]  req_factor,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_out_x,
   output logic signed [15:0]  rsp_out_y,
   output logic signed [15:0]  rsp_out_z,
   output logic signed [15:0]  rsp_out_w,
   output logic [20:0]         rsp_out_norm_sq,
   output logic [1:0]          rsp_status
);

   logic                           en;
   logic [PIPE_DEPTH-1:0]          vld_ff, vld_in;
   logic [LANES-1:0][LANES-1:0][W-1:0] lane_a, lane_b;
   logic [LANES-1:0][LANES-1:0]    lane_neg;
   logic [LANES-1:0][W-1:0]        lane_own_b;
   logic [LANES-1:0][W-1:0]        a_vec;
   logic [LANES-1:0][W-1:0]        comp;
   logic [SUM_W-1:0]               norm_sum;
   norm_out_type                   norm_out;
   lane_out_type                   lane_out [LANES];

   assign en        = ~(vld_ff[PIPE_DEPTH-1] & rsp_stall);
   assign req_stall = ~en;
   assign vld_in    = en ? {vld_ff[PIPE_DEPTH-2:0], req_valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      a_vec = {req_a_w, req_a_z, req_a_y, req_a_x};
      lane_a[0] = {req_a_z, req_a_y, req_a_w, req_a_x};
      lane_b[0] = {req_b_y, req_b_z, req_b_x, req_b_w};
      lane_a[1] = {req_a_x, req_a_z, req_a_w, req_a_y};
      lane_b[1] = {req_b_z, req_b_x, req_b_y, req_b_w};
      lane_a[2] = {req_a_y, req_a_x, req_a_w, req_a_z};
      lane_b[2] = {req_b_x, req_b_y, req_b_z, req_b_w};
      lane_a[3] = {req_a_z, req_a_y, req_a_x, req_a_w};
      lane_b[3] = {req_b_z, req_b_y, req_b_x, req_b_w};
      lane_neg[0] = 4'b1000;
      lane_neg[1] = 4'b1000;
      lane_neg[2] = 4'b1000;
      lane_neg[3] = 4'b1110;
      lane_own_b = {req_b_w, req_b_z, req_b_y, req_b_x};
   end

   qau_norm u_norm (
      .clock    (clock),
      .en       (en),
      .a        (a_vec),
      .norm_sum (norm_sum),
      .norm_out (norm_out)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      qau_lane u_lane (
         .clock     (clock),
         .en        (en),
         .real_part (l == LANES - 1),
         .cmd       (req_cmd),
         .hp_a      (lane_a[l]),
         .hp_b      (lane_b[l]),
         .hp_neg    (lane_neg[l]),
         .own_b     (lane_own_b[l]),
         .factor    (req_factor),
         .norm_sum  (norm_sum),
         .lane_out  (lane_out[l])
      );
   end

   qau_merge u_merge (
      .clock    (clock),
      .en       (en),
      .lane_out (lane_out),
      .norm_out (norm_out),
      .comp     (comp),
      .norm_sq  (rsp_out_norm_sq),
      .status   (rsp_status)
   );

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_out_x = comp[0];
   assign rsp_out_y = comp[1];
   assign rsp_out_z = comp[2];
   assign rsp_out_w = comp[3];

endmodule

/* design/qau_checker.sv */
// Port-level checker for the quaternion unit and its bind to the top level.
module qau_checker
   import qau_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [15:0]  rsp_out_x,
   input logic signed [15:0]  rsp_out_y,
   input logic signed [15:0]  rsp_out_z,
   input logic signed [15:0]  rsp_out_w,
   input logic [1:0]          rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIVZ |->
         rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0 && rsp_out_w == '0)
      else $error("division by zero beat carries nonzero components");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (.*);

/* dv/quaternion_arithmetic_unit_top_tb.sv */
// Self-checking testbench of the quaternion arithmetic unit with a scoreboard class.
`timescale 1ns / 100ps

module quaternion_arithmetic_unit_top_tb
   import qau_pkg::*;
;

   typedef struct {
      logic signed [15:0] x, y, z, w;
      logic [20:0]        nrm;
      logic [1:0]         st;
   } quat_result_type;

   class quat_scoreboard;
      quat_result_type pending[$];
      int              errors;

      function longint sat_add64(longint a, longint b);
         if (b > 0 && a > 64'sh7fffffffffffffff - b) return 64'sh7fffffffffffffff;
         if (b < 0 && a < -64'sh7fffffffffffffff - 1 - b) return -64'sh7fffffffffffffff - 1;
         return a + b;
      endfunction

      function longint round_q(longint v);
         return sat_add64(v, 64'sd2048) >>> FB;
      endfunction

      // rounded quotient of |n| * 2^s / d, ties away from zero, capped at 2^16
      function longint quot(longint n, int s, longint unsigned d, bit neg);
         longint unsigned m, q, r;
         logic [127:0] num, qq, rr;
         m = (n < 0) ? -n : n;
         num = {64'd0, m} << s;
         qq = num / d;
         rr = num % d;
         if (qq > 128'd65536) q = 65536;
         else begin
            q = qq[63:0];
            if ((rr << 1) >= d) q++;
            if (q > 65536) q = 65536;
         end
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function void note_request(logic [3:0] cmd, logic signed [15:0] av[4],
                                 logic signed [15:0] bv[4], logic signed [15:0] f);
         longint a[4], b[4], r[4], fl;
         longint unsigned ssum, nrm;
         bit sat, dz;
         quat_result_type e;
         sat = 0; dz = 0; ssum = 0; fl = f;
         foreach (a[i]) begin
            a[i] = av[i]; b[i] = bv[i]; r[i] = 0;
            ssum += longint'(a[i] * a[i]);
         end
         nrm = (ssum >> FB) + ((ssum >> (FB - 1)) & 1);
         if (nrm > 21'h1fffff) begin nrm = 21'h1fffff; sat = 1; end
         case (cmd)
            CMD_ADD: foreach (r[i]) r[i] = a[i] + b[i];
            CMD_SUB: foreach (r[i]) r[i] = a[i] - b[i];
            CMD_NEG: foreach (r[i]) r[i] = -a[i];
            CMD_CONJ: begin
               r[0] = -a[0]; r[1] = -a[1]; r[2] = -a[2]; r[3] = a[3];
            end
            CMD_PROD: begin
               r[0] = round_q(a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1]);
               r[1] = round_q(a[1]*b[3] + a[3]*b[1] + a[2]*b[0] - a[0]*b[2]);
               r[2] = round_q(a[2]*b[3] + a[3]*b[2] + a[0]*b[1] - a[1]*b[0]);
               r[3] = round_q(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2]);
            end
            CMD_SCL: foreach (r[i]) r[i] = round_q(a[i] * fl);
            CMD_DIVS: begin
               if (fl == 0) dz = 1;
               else foreach (r[i])
                  r[i] = quot(a[i], FB, (fl < 0) ? -fl : fl, (a[i] < 0) != (fl < 0));
            end
            CMD_DIVC: begin
               foreach (b[i]) if (b[i] == 0) dz = 1;
               if (!dz) foreach (r[i])
                  r[i] = quot(a[i], FB, (b[i] < 0) ? -b[i] : b[i], (a[i] < 0) != (b[i] < 0));
            end
            CMD_INV: begin
               if (ssum == 0) dz = 1;
               else foreach (r[i])
                  r[i] = quot(a[i], 2 * FB, ssum, (i < 3) ? (a[i] >= 0) : (a[i] < 0));
            end
            default: ;
         endcase
         foreach (r[i]) begin
            if (r[i] > 32767) begin r[i] = 32767; sat = 1; end
            if (r[i] < -32768) begin r[i] = -32768; sat = 1; end
         end
         e.x = 16'(r[0]); e.y = 16'(r[1]); e.z = 16'(r[2]); e.w = 16'(r[3]);
         e.nrm = 21'(nrm);
         e.st = dz ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
         pending.push_back(e);
      endfunction

      function void check_response(quat_result_type got);
         quat_result_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected response beat", $time);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.x !== e.x) begin
            $display("%0t out_x expected %0d actual %0d", $time, e.x, got.x); errors++;
         end
         if (got.y !== e.y) begin
            $display("%0t out_y expected %0d actual %0d", $time, e.y, got.y); errors++;
         end
         if (got.z !== e.z) begin
            $display("%0t out_z expected %0d actual %0d", $time, e.z, got.z); errors++;
         end
         if (got.w !== e.w) begin
            $display("%0t out_w expected %0d actual %0d", $time, e.w, got.w); errors++;
         end
         if (got.nrm !== e.nrm) begin
            $display("%0t norm_sq expected %0d actual %0d", $time, e.nrm, got.nrm); errors++;
         end
         if (got.st !== e.st) begin
            $display("%0t status expected %0d actual %0d", $time, e.st, got.st); errors++;
         end
      endfunction
   endclass

   logic               clock, reset;
   logic               req_valid, req_stall, rsp_valid, rsp_stall;
   logic [3:0]         req_cmd;
   logic signed [15:0] req_a_x, req_a_y, req_a_z, req_a_w;
   logic signed [15:0] req_b_x, req_b_y, req_b_z, req_b_w, req_factor;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic [20:0]        rsp_out_norm_sq;
   logic [1:0]         rsp_status;

   quat_scoreboard sb;

   quaternion_arithmetic_unit_top dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return -16'sh8000;
         2: return 16'sh0000;
         3: return 16'sh1000;
         4: return 16'($urandom_range(0, 8191) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_beat(logic [3:0] cmd, logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az, logic signed [15:0] aw,
                            logic signed [15:0] bx, logic signed [15:0] by,
                            logic signed [15:0] bz, logic signed [15:0] bw,
                            logic signed [15:0] f);
      logic signed [15:0] av[4], bv[4];
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1; req_cmd <= cmd;
      req_a_x <= ax; req_a_y <= ay; req_a_z <= az; req_a_w <= aw;
      req_b_x <= bx; req_b_y <= by; req_b_z <= bz; req_b_w <= bw;
      req_factor <= f;
      av = '{ax, ay, az, aw}; bv = '{bx, by, bz, bw};
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, av, bv, f);
      @(negedge clock);
   endtask

   task automatic send_random(logic [3:0] cmd);
      send_beat(cmd, pick_value(), pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
   endtask

   initial begin
      int g;
      rsp_stall = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_stall <= 1;
            repeat (g) @(negedge clock);
         end
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      quat_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_out_x; got.y = rsp_out_y; got.z = rsp_out_z; got.w = rsp_out_w;
         got.nrm = rsp_out_norm_sq; got.st = rsp_status;
         sb.check_response(got);
      end
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic signed [15:0] mx, mn;
      sb = new();
      mx = 16'sh7fff; mn = -16'sh8000;
      reset = 1; req_valid = 0; req_cmd = 0;
      {req_a_x, req_a_y, req_a_z, req_a_w} = '0;
      {req_b_x, req_b_y, req_b_z, req_b_w, req_factor} = '0;
      repeat (9) @(negedge clock);
      reset = 0;
      @(negedge clock);
      send_beat(CMD_ADD, mx, mx, mn, mn, mx, mn, mn, mx, 0);
      send_beat(CMD_SUB, mx, mn, 0, 1, mn, mx, 0, -1, 0);
      send_beat(CMD_NEG, mn, mx, 0, -1, 0, 0, 0, 0, 0);
      send_beat(CMD_CONJ, mn, mx, 1, mn, 0, 0, 0, 0, 0);
      send_beat(CMD_PROD, mx, mx, mx, mx, mn, mn, mn, mn, 0);
      send_beat(CMD_PROD, 16'sh1000, 0, 0, 0, 0, 16'sh1000, 0, 0, 0);
      send_beat(CMD_SCL, mx, mn, 1, -1, 0, 0, 0, 0, mn);
      send_beat(CMD_SCL, 16'sh0800, -16'sh0800, 1, -1, 0, 0, 0, 0, 16'sh0001);
      send_beat(CMD_DIVS, mx, mn, 1, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_DIVS, mx, mn, 1, -1, 0, 0, 0, 0, 1);
      send_beat(CMD_DIVS, mn, 3, -3, 16'sh1000, 0, 0, 0, 0, mn);
      send_beat(CMD_DIVC, 1, 2, 3, 4, 1, 0, 1, 1, 0);
      send_beat(CMD_DIVC, mx, mn, 16'sh1000, -5, 3, -1, mn, 2, 0);
      send_beat(CMD_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_INV, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_INV, mn, mn, mn, mn, 0, 0, 0, 0, 0);
      send_beat(CMD_INV, 0, 0, 0, 16'sh1000, 0, 0, 0, 0, 0);
      send_beat(CMD_NORM, mn, mn, mn, mn, 0, 0, 0, 0, 0);
      send_beat(CMD_NORM, mx, 0, 0, 0, 0, 0, 0, 0, 0);
      send_beat(4'd10, mx, mx, mx, mx, mx, mx, mx, mx, mx);
      send_beat(4'd15, 1, 2, 3, 4, 5, 6, 7, 8, 9);
      // hold off until the pipeline drains
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      for (int n = 0; n < 630; n++) begin
         if ($urandom_range(0, 15) == 0) send_beat(4'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom));
         else send_random(4'($urandom_range(0, 9)));
      end
      req_valid <= 0;
      fork
         while (sb.pending.size() != 0) @(negedge clock);
         begin
            repeat (5000) @(negedge clock);
            $display("RESULT: ERROR");
            $finish;
         end
      join_any
      disable fork;
      repeat (40) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
